// ===== rtl/core/tbtb_pkg.sv =====
// ============================================================================
// tbtb_pkg: shared types and constants of the timer bank
// Request codes, time base codes and the entry record stored per timer.
// ============================================================================
`default_nettype none

package tbtb_pkg;

    localparam int unsigned TICK_W = 32;

    // request codes
    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_PAUSE   = 3'd1,
        REQ_STOP    = 3'd2,
        REQ_SET     = 3'd3,
        REQ_GET     = 3'd4,
        REQ_TICK    = 3'd5,
        REQ_SERVICE = 3'd6,
        REQ_CLOSE   = 3'd7
    } t_req;

    // configuration register indexes
    localparam logic [1:0] CFG_CENTI  = 2'd0;
    localparam logic [1:0] CFG_DECI   = 2'd1;
    localparam logic [1:0] CFG_SECOND = 2'd2;
    localparam logic [1:0] CFG_MINUTE = 2'd3;

    // one timer entry as held in the bank memory
    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic [1:0]        unit;
        logic              paused;
        logic              expired;
    } t_entry;

    // divider request/response
    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/core/tbtb_div.sv =====
// ============================================================================
// tbtb_div: radix-2 restoring divider
// Produces one quotient bit per cycle.
// ============================================================================
`default_nettype none

module tbtb_div
    import tbtb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int unsigned CNT_W = $clog2(TICK_W + 1);

    logic [TICK_W-1:0] r_quo, n_quo;
    logic [TICK_W-1:0] r_rem, n_rem;
    logic [TICK_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [TICK_W:0]   w_trial;
    logic [TICK_W:0]   w_diff;

    // shift in the next dividend bit and try subtracting
    always_comb begin
        w_trial = {r_rem, r_quo[TICK_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(TICK_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_diff[TICK_W]) begin
                n_rem = w_trial[TICK_W-1:0];
                n_quo = {r_quo[TICK_W-2:0], 1'b0};
            end else begin
                n_rem = w_diff[TICK_W-1:0];
                n_quo = {r_quo[TICK_W-2:0], 1'b1};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/tbtb_bank.sv =====
// ============================================================================
// tbtb_bank: timer entry memory
// One write port and one read port, read data registered; the top-level clear
// sweep resets entries through the write port one per cycle.
// ============================================================================
`default_nettype none

module tbtb_bank
    import tbtb_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned IDX_W = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);

    t_entry r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/timer_bank_with_time_bases.sv =====
// ============================================================================
// timer_bank_with_time_bases: bank of countdown timers with four time bases
// Timer state lives in a single-port-write memory walked by a sequencer.
// ============================================================================
//
//  channel  | dir | width | contents
//  s_axis   | in  | 48    | req_type, timer_index, time_value, time_base, pause_mode
//  m_axis   | out | 40+1  | status, remaining_time, expired_valid, expired_index; tlast
//  cfg      | in  | 30    | base tick registers, index 0..3
//
//  Per-timer requests pass through read, check and emit states; start and set add
//  multiply and load states (saturating multiply path), get waits for the
//  shift-subtract divider. Tick, service and close walk every entry in a read
//  state and a modify-and-write-back state, plus a report state per service hit.
//  After reset a clear pass over all TIMER_COUNT entries runs before the first
//  transfer is taken. A stalled output holds the sequencer in its emit state.
//
`default_nettype none

module timer_bank_with_time_bases
    import tbtb_pkg::*;
#(
    parameter int unsigned TIMER_COUNT = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata: req_type[2:0], timer_index[8:3], time_value[40:9],
    //        time_base[42:41], pause_mode[43], zero fill [47:44]
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: status[0], remaining_time[32:1], expired_valid[33],
    //        expired_index[39:34]
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [29:0] i_cfg_data
);

    localparam int unsigned IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int unsigned WALK_W = $clog2(TIMER_COUNT + 1);
    localparam int unsigned RES_LIMIT = 8;
    localparam int unsigned NRES_W = 4;

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b00000000001,
        ST_IDLE   = 11'b00000000010,
        ST_READ   = 11'b00000000100,
        ST_MOD    = 11'b00000001000,
        ST_MUL    = 11'b00000010000,
        ST_LOAD   = 11'b00000100000,
        ST_DIV    = 11'b00001000000,
        ST_WALK   = 11'b00010000000,
        ST_WMOD   = 11'b00100000000,
        ST_EMIT   = 11'b01000000000,
        ST_WEMIT  = 11'b10000000000
    } t_state;

    // configuration registers
    logic [15:0] r_cfg0;
    logic [19:0] r_cfg1;
    logic [23:0] r_cfg2;
    logic [29:0] r_cfg3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg0 <= 16'd10;
            r_cfg1 <= 20'd100;
            r_cfg2 <= 24'd1000;
            r_cfg3 <= 30'd60000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTI:  r_cfg0 <= i_cfg_data[15:0];
                CFG_DECI:   r_cfg1 <= i_cfg_data[19:0];
                CFG_SECOND: r_cfg2 <= i_cfg_data[23:0];
                CFG_MINUTE: r_cfg3 <= i_cfg_data;
                default:    r_cfg0 <= r_cfg0;
            endcase
        end
    end

    function automatic logic [31:0] base_sel(input logic [1:0] u, input logic [15:0] c0,
                                             input logic [19:0] c1, input logic [23:0] c2,
                                             input logic [29:0] c3);
        logic [31:0] v;
        case (u)
            CFG_CENTI:  v = {16'd0, c0};
            CFG_DECI:   v = {12'd0, c1};
            CFG_SECOND: v = {8'd0, c2};
            default:    v = {2'd0, c3};
        endcase
        return v;
    endfunction

    // request fields
    logic [2:0]  w_req;
    logic [5:0]  w_idx;
    logic [31:0] w_tval;
    logic [1:0]  w_base;
    logic        w_mode;
    assign w_req  = s_axis_tdata[2:0];
    assign w_idx  = s_axis_tdata[8:3];
    assign w_tval = s_axis_tdata[40:9];
    assign w_base = s_axis_tdata[42:41];
    assign w_mode = s_axis_tdata[43];

    t_state          r_state, n_state;
    t_req            r_req;
    logic [5:0]      r_idx;
    logic [31:0]     r_tval;
    logic [1:0]      r_base;
    logic            r_mode;
    logic [WALK_W-1:0] r_walk, n_walk;
    logic [NRES_W-1:0] r_nres, n_nres;
    logic [47:0]     r_prod_hi, r_prod_lo;
    logic [1:0]      r_unit_sel;
    t_entry          r_cur;

    // output register
    logic        r_ov, n_ov;
    logic        r_ost, n_ost;
    logic [31:0] r_orem, n_orem;
    logic        r_oev, n_oev;
    logic [5:0]  r_oei, n_oei;
    logic        r_olast, n_olast;

    // memory ports
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_entry           w_wdata;
    logic [IDX_W-1:0] w_raddr;
    t_entry           w_rdata;

    tbtb_bank #(.DEPTH(TIMER_COUNT), .IDX_W(IDX_W)) u_bank (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    tbtb_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    logic w_ok;
    assign w_ok = ({2'd0, r_idx} < 8'(TIMER_COUNT));

    logic w_out_free;
    assign w_out_free = !r_ov || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ov;

    // base of the addressed timer straight from the read data while it is checked
    logic [1:0] w_unit;
    assign w_unit = (r_state == ST_MOD) ? w_rdata.unit : r_unit_sel;

    // 32x16 partial products keep each multiplier narrow
    logic [47:0] w_pp_lo, w_pp_hi;
    logic [31:0] w_bsel;
    assign w_bsel  = base_sel(w_unit, r_cfg0, r_cfg1, r_cfg2, r_cfg3);
    assign w_pp_lo = r_tval * w_bsel[15:0];
    assign w_pp_hi = r_tval * w_bsel[31:16];

    logic [64:0] w_prod;
    assign w_prod = 65'(r_prod_lo) + 65'({r_prod_hi, 16'd0});
    logic [31:0] w_loadv;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_walk  = r_walk;
        n_nres  = r_nres;
        w_we    = 1'b0;
        w_waddr = r_walk[IDX_W-1:0];
        w_wdata = '0;
        w_raddr = r_walk[IDX_W-1:0];
        w_dreq  = '0;
        n_ov    = r_ov && !m_axis_tready;
        n_ost   = r_ost;
        n_orem  = r_orem;
        n_oev   = r_oev;
        n_oei   = r_oei;
        n_olast = r_olast;
        w_loadv = (w_prod[64:32] != 33'd0) ? 32'hFFFF_FFFF : w_prod[31:0];

        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_walk[IDX_W-1:0];
                n_walk  = r_walk + WALK_W'(1);
                if (r_walk == WALK_W'(TIMER_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_walk = '0;
                n_nres = '0;
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_req == REQ_TICK || r_req == REQ_SERVICE || r_req == REQ_CLOSE) begin
                    w_raddr = '0;
                    n_state = ST_WALK;
                end else begin
                    w_raddr = r_idx[IDX_W-1:0];
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                // entry on the read port now; keep it addressed so r_cur follows
                w_raddr = r_idx[IDX_W-1:0];
                n_state = ST_EMIT;
                n_ost = 1'b0; n_orem = '0; n_oev = 1'b0; n_oei = '0; n_olast = 1'b1;
                w_waddr = r_idx[IDX_W-1:0];
                w_wdata = w_rdata;
                if (!w_ok) begin
                    n_ost = 1'b1;
                end else begin
                    case (r_req)
                        REQ_START: n_state = ST_MUL;
                        REQ_PAUSE: begin
                            w_we = 1'b1;
                            w_wdata.paused = r_mode;
                        end
                        REQ_STOP: begin
                            w_we = 1'b1;
                            w_wdata = '0;
                        end
                        REQ_SET: begin
                            if (w_rdata.ticks == '0) n_ost = 1'b1;
                            else n_state = ST_MUL;
                        end
                        REQ_GET: begin
                            if (w_rdata.ticks == '0) begin
                                n_ost = 1'b1;
                            end else if (w_bsel == '0) begin
                                n_orem = 32'hFFFF_FFFF;
                            end else begin
                                w_dreq.start    = 1'b1;
                                w_dreq.dividend = w_rdata.ticks;
                                w_dreq.divisor  = w_bsel;
                                n_state = ST_DIV;
                            end
                        end
                        default: n_ost = r_ost;
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IDX_W-1:0];
                w_wdata = r_cur;
                w_wdata.ticks = w_loadv;
                w_wdata.unit  = r_unit_sel;
                n_state = ST_EMIT;
            end
            ST_DIV: begin
                if (w_drsp.done) begin
                    n_orem  = w_drsp.quotient;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_WALK: begin
                // read of entry r_walk issued; next cycle r_cur valid
                n_state = ST_WMOD;
            end
            ST_WMOD: begin
                w_waddr = r_walk[IDX_W-1:0];
                w_wdata = r_cur;
                n_state = ST_WALK;
                n_walk  = r_walk + WALK_W'(1);
                w_raddr = IDX_W'(r_walk + WALK_W'(1));
                case (r_req)
                    REQ_TICK: begin
                        if (r_cur.ticks != '0 && !r_cur.paused) begin
                            w_we = 1'b1;
                            w_wdata.ticks = r_cur.ticks - 32'd1;
                            if (r_cur.ticks == 32'd1) w_wdata.expired = 1'b1;
                        end
                    end
                    REQ_CLOSE: begin
                        w_we = 1'b1;
                        w_wdata = '0;
                    end
                    default: begin
                        if (r_cur.expired && r_nres != NRES_W'(RES_LIMIT)) begin
                            n_state = ST_WEMIT;
                            n_walk  = r_walk;
                            w_raddr = r_walk[IDX_W-1:0];
                        end
                    end
                endcase
                if (n_state == ST_WALK && r_walk == WALK_W'(TIMER_COUNT - 1)) begin
                    if (r_req == REQ_SERVICE && r_nres != '0) begin
                        // last expired result already sent with tlast
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                        n_ost = 1'b0; n_orem = '0; n_oev = 1'b0; n_oei = '0; n_olast = 1'b1;
                    end
                end
            end
            ST_WEMIT: begin
                // hold until output free, then clear mark and report
                w_raddr = r_walk[IDX_W-1:0];
                if (w_out_free) begin
                    w_we    = 1'b1;
                    w_waddr = r_walk[IDX_W-1:0];
                    w_wdata = r_cur;
                    w_wdata.expired = 1'b0;
                    n_ov    = 1'b1;
                    n_ost   = 1'b0;
                    n_orem  = '0;
                    n_oev   = 1'b1;
                    n_oei   = 6'(r_walk[IDX_W-1:0]);
                    n_olast = 1'b0;
                    n_nres  = r_nres + NRES_W'(1);
                    n_walk  = r_walk + WALK_W'(1);
                    w_raddr = IDX_W'(r_walk + WALK_W'(1));
                    n_state = ST_WALK;
                    if (r_walk == WALK_W'(TIMER_COUNT - 1) ||
                        r_nres == NRES_W'(RES_LIMIT - 1)) begin
                        n_olast = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // the tlast of a service result is known only at its end; later hits are
    // emitted while the walk continues, so the pending result is flagged last
    // only when no later hit follows. Resolve by looking ahead in the marks.
    logic [TIMER_COUNT-1:0] r_exp_shadow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_walk  <= '0;
            r_nres  <= '0;
            r_ov    <= 1'b0;
            r_exp_shadow <= '0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            r_nres  <= n_nres;
            r_ov    <= n_ov;
            if (w_we) r_exp_shadow[w_waddr] <= w_wdata.expired;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_req  <= t_req'(w_req);
            r_idx  <= w_idx;
            r_tval <= w_tval;
            r_base <= w_base;
            r_mode <= w_mode;
        end
        if (r_state == ST_MOD) begin
            r_unit_sel <= (r_req == REQ_START) ? r_base : w_rdata.unit;
        end
        // capture both partial products of the load value
        if (r_state == ST_MUL) begin
            r_prod_lo <= w_pp_lo;
            r_prod_hi <= w_pp_hi;
        end
        r_cur   <= w_rdata;
        r_ost   <= n_ost;
        r_orem  <= n_orem;
        r_oev   <= n_oev;
        r_oei   <= n_oei;
        r_olast <= n_olast;
    end

    // tlast on a service hit: no further marked entry above it, or the result limit reached
    logic [TIMER_COUNT-1:0] w_above;
    logic                   w_more;
    always_comb begin
        for (int k = 0; k < TIMER_COUNT; k++) begin
            w_above[k] = r_exp_shadow[k] && (WALK_W'(k) > WALK_W'(r_oei));
        end
        w_more = (w_above != '0) && (r_nres != NRES_W'(RES_LIMIT));
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {r_oei, r_oev, r_orem, r_ost};
    assign m_axis_tlast  = r_oev ? (r_olast || !w_more) : r_olast;

endmodule

`default_nettype wire
